@@ sv/sha1_pkg.sv @@
package sha1_pkg;

  localparam int WORD_W     = 32;
  localparam int HASH_WORDS = 5;
  localparam int WIN_WORDS  = 16;
  localparam int RND_W      = 7;
  localparam int FILL_W     = 6;
  localparam int LEN_W      = 64;
  localparam int IDX_W      = 3;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [RND_W-1:0]  rnd_t;

  localparam rnd_t ROUND_LAST = rnd_t'(79);
  localparam rnd_t ROUND_P1   = rnd_t'(20);
  localparam rnd_t ROUND_P2   = rnd_t'(40);
  localparam rnd_t ROUND_P3   = rnd_t'(60);

  localparam word_t IV [HASH_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam word_t K0 = 32'h5a827999;
  localparam word_t K1 = 32'h6ed9eba1;
  localparam word_t K2 = 32'h8f1bbcdc;
  localparam word_t K3 = 32'hca62c1d6;

  localparam logic [7:0]        PAD_MARK   = 8'h80;
  localparam logic [7:0]        PAD_ZERO   = 8'h00;
  localparam logic [FILL_W-1:0] PAD_LEN_POS = FILL_W'(56);
  localparam logic [FILL_W-1:0] BLOCK_LAST  = FILL_W'(63);
  localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(HASH_WORDS - 1);
  localparam logic [LEN_W-1:0]  BYTE_BITS   = LEN_W'(8);

  typedef struct packed {
    logic  push;
    logic  start;
    logic  init;
    word_t word;
  } core_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  function automatic word_t round_k(input rnd_t rnd);
    word_t k;
    if (rnd < ROUND_P1) k = K0;
    else if (rnd < ROUND_P2) k = K1;
    else if (rnd < ROUND_P3) k = K2;
    else k = K3;
    return k;
  endfunction

  function automatic word_t round_f(input rnd_t rnd, input word_t b, input word_t c,
                                    input word_t d);
    word_t f;
    if (rnd < ROUND_P1) f = (b & c) | (~b & d);
    else if (rnd < ROUND_P2) f = b ^ c ^ d;
    else if (rnd < ROUND_P3) f = (b & c) | (b & d) | (c & d);
    else f = b ^ c ^ d;
    return f;
  endfunction

endpackage

@@ sv/sha1_if.sv @@
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source (output valid, output data_byte, output byte_valid,
                  output end_of_message, input ready);
  modport sink (input valid, input data_byte, input byte_valid,
                input end_of_message, output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink (input valid, input digest_word, input word_index,
                input last_word, output ready);
endinterface

@@ sv/sha1_core.sv @@
module sha1_core import sha1_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  core_ctrl_t ctrl_i,
  output core_stat_t stat_o,
  output word_t      hash_o [HASH_WORDS]
);

  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD} cstate_e;

  cstate_e state_q;
  rnd_t    rnd_q;
  word_t   hash_q [HASH_WORDS];
  word_t   a_q, b_q, c_q, d_q, e_q;
  word_t   win_q [WIN_WORDS];

  word_t tmp;
  word_t sched_x;
  word_t sched;
  logic  shift_en;
  word_t shift_word;

  assign tmp = {a_q[26:0], a_q[31:27]} + round_f(rnd_q, b_q, c_q, d_q) + e_q
             + round_k(rnd_q) + win_q[0];
  assign sched_x    = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
  assign sched      = {sched_x[30:0], sched_x[31]};
  assign shift_en   = (state_q == C_ROUND) || (state_q == C_IDLE && ctrl_i.push);
  assign shift_word = (state_q == C_ROUND) ? sched : ctrl_i.word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      rnd_q   <= '0;
      for (int i = 0; i < HASH_WORDS; i++) hash_q[i] <= IV[i];
    end else begin
      case (state_q)
        C_IDLE: begin
          if (ctrl_i.init) begin
            for (int i = 0; i < HASH_WORDS; i++) hash_q[i] <= IV[i];
          end
          if (ctrl_i.start) begin
            rnd_q   <= '0;
            state_q <= C_ROUND;
          end
        end
        C_ROUND: begin
          rnd_q <= rnd_q + rnd_t'(1);
          if (rnd_q == ROUND_LAST) state_q <= C_ADD;
        end
        C_ADD: begin
          hash_q[0] <= hash_q[0] + a_q;
          hash_q[1] <= hash_q[1] + b_q;
          hash_q[2] <= hash_q[2] + c_q;
          hash_q[3] <= hash_q[3] + d_q;
          hash_q[4] <= hash_q[4] + e_q;
          state_q   <= C_IDLE;
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == C_IDLE && ctrl_i.start) begin
      a_q <= hash_q[0];
      b_q <= hash_q[1];
      c_q <= hash_q[2];
      d_q <= hash_q[3];
      e_q <= hash_q[4];
    end else if (state_q == C_ROUND) begin
      a_q <= tmp;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
    if (shift_en) begin
      for (int i = 0; i < WIN_WORDS - 1; i++) win_q[i] <= win_q[i+1];
      win_q[WIN_WORDS-1] <= shift_word;
    end
  end

  assign stat_o.busy = (state_q != C_IDLE);
  assign stat_o.done = (state_q == C_ADD);
  assign hash_o      = hash_q;

endmodule

@@ sv/sha1_message_digest.sv @@
// channel   | dir | handshake     | payload
// msg_i     | in  | valid / ready | data_byte[7:0], byte_valid, end_of_message
// digest_o  | out | valid / ready | digest_word[31:0], word_index[2:0], last_word
//
// one message byte is taken per cycle while no block is being compressed or padded and no digest is being output
// the 64th byte of a block starts 80 rounds followed by an add step
// an end word pads one byte per cycle between compressions, compressing once or twice, then gives 5 words
// ready is low from a full block until its compression finishes, and during padding and output
// rst_ni clears control and loads the initial hash values at once
module sha1_message_digest import sha1_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sha1_in_if.sink     msg_i,
  sha1_out_if.source  digest_o
);

  typedef enum logic [1:0] {S_IDLE, S_PAD, S_COMP, S_OUT} state_e;
  typedef enum logic [1:0] {PH_MARK, PH_ZERO, PH_LEN} phase_e;
  typedef enum logic [1:0] {NX_IDLE, NX_PAD, NX_OUT} after_e;

  state_e            state_q;
  phase_e            phase_q;
  after_e            after_q;
  logic [FILL_W-1:0] fill_q;
  logic [23:0]       acc_q;
  logic [LEN_W-1:0]  len_q;
  logic [IDX_W-1:0]  idx_q;

  logic       in_acc;
  logic       out_acc;
  logic [2:0] lsel;
  logic [7:0] len_byte;
  logic       put_en;
  logic [7:0] put_byte;
  logic       blk_full;

  core_ctrl_t ctrl;
  core_stat_t stat;
  word_t      hash [HASH_WORDS];

  assign in_acc   = msg_i.valid && msg_i.ready;
  assign out_acc  = digest_o.valid && digest_o.ready;
  assign lsel     = 3'd7 - fill_q[2:0];
  assign len_byte = len_q[{lsel, 3'b000} +: 8];

  always_comb begin
    put_en   = 1'b0;
    put_byte = msg_i.data_byte;
    case (state_q)
      S_IDLE: put_en = in_acc && msg_i.byte_valid;
      S_PAD: begin
        put_en = 1'b1;
        case (phase_q)
          PH_MARK: put_byte = PAD_MARK;
          PH_ZERO: put_byte = (fill_q == PAD_LEN_POS) ? len_byte : PAD_ZERO;
          PH_LEN:  put_byte = len_byte;
          default: put_byte = PAD_ZERO;
        endcase
      end
      default: put_en = 1'b0;
    endcase
  end

  assign blk_full   = put_en && (fill_q == BLOCK_LAST);
  assign ctrl.push  = put_en && (fill_q[1:0] == 2'b11);
  assign ctrl.start = blk_full;
  assign ctrl.init  = out_acc && (idx_q == LAST_IDX);
  assign ctrl.word  = {acc_q, put_byte};

  sha1_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .hash_o (hash)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_MARK;
      after_q <= NX_IDLE;
      fill_q  <= '0;
      acc_q   <= '0;
      len_q   <= '0;
      idx_q   <= '0;
    end else begin
      if (put_en) begin
        acc_q  <= {acc_q[15:0], put_byte};
        fill_q <= fill_q + FILL_W'(1);
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (msg_i.byte_valid) len_q <= len_q + BYTE_BITS;
            if (msg_i.end_of_message) phase_q <= PH_MARK;
            if (blk_full) begin
              state_q <= S_COMP;
              after_q <= msg_i.end_of_message ? NX_PAD : NX_IDLE;
            end else if (msg_i.end_of_message) begin
              state_q <= S_PAD;
            end
          end
        end
        S_PAD: begin
          case (phase_q)
            PH_MARK: phase_q <= PH_ZERO;
            PH_ZERO: if (fill_q == PAD_LEN_POS) phase_q <= PH_LEN;
            default: phase_q <= phase_q;
          endcase
          if (blk_full) begin
            state_q <= S_COMP;
            after_q <= (phase_q == PH_LEN) ? NX_OUT : NX_PAD;
          end
        end
        S_COMP: begin
          if (stat.done) begin
            case (after_q)
              NX_PAD: state_q <= S_PAD;
              NX_OUT: begin
                state_q <= S_OUT;
                idx_q   <= '0;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_OUT: begin
          if (out_acc) begin
            if (idx_q == LAST_IDX) begin
              state_q <= S_IDLE;
              len_q   <= '0;
              idx_q   <= '0;
            end else begin
              idx_q <= idx_q + IDX_W'(1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign msg_i.ready          = (state_q == S_IDLE);
  assign digest_o.valid       = (state_q == S_OUT);
  assign digest_o.digest_word = hash[idx_q];
  assign digest_o.word_index  = idx_q;
  assign digest_o.last_word   = (idx_q == LAST_IDX);

  a_ready_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_i.ready |-> !digest_o.valid)
    else $error("input ready while a digest word is offered");

  a_core_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.busy |-> !msg_i.ready)
    else $error("input ready during compression");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && digest_o.last_word) |=> (msg_i.ready && fill_q == '0 && len_q == '0))
    else $error("state not cleared after final digest word");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digest_o.valid |-> (digest_o.word_index <= LAST_IDX))
    else $error("digest word index out of range");

endmodule

@@ sim/sha1_message_digest_tb.sv @@
module sha1_message_digest_tb import sha1_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RAND_WORDS   = 400;
  localparam int HOLD_CYCLES  = 1000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
    logic       known_empty;
  } stim_row_t;

  typedef struct packed {
    word_t      digest_word;
    logic [2:0] word_index;
    logic       last_word;
  } digest_rec_t;

  localparam word_t EMPTY_DIGEST [HASH_WORDS] = '{
    32'hDA39A3EE, 32'h5E6B4B0D, 32'h3255BFEF, 32'h95601890, 32'hAFD80709
  };

  localparam int DIR_COUNT = 18;
  localparam stim_row_t DIR_ROWS [DIR_COUNT] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1},
    '{8'h5A, 1'b0, 1'b0, 1'b0},
    '{8'hA5, 1'b0, 1'b1, 1'b1},
    '{8'h00, 1'b1, 1'b0, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 1'b0},
    '{8'h61, 1'b1, 1'b0, 1'b0},
    '{8'h62, 1'b1, 1'b0, 1'b0},
    '{8'h63, 1'b1, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 1'b0},
    '{8'h01, 1'b1, 1'b0, 1'b0},
    '{8'hC3, 1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b1, 1'b0, 1'b0},
    '{8'h7E, 1'b1, 1'b1, 1'b0},
    '{8'h00, 1'b1, 1'b1, 1'b0},
    '{8'h00, 1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b1, 1'b1}
  };

  logic clk_i;
  logic rst_ni;

  sha1_in_if  msg_ch ();
  sha1_out_if dig_ch ();

  sha1_message_digest uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .msg_i    (msg_ch),
    .digest_o (dig_ch)
  );

  word_t       chain_h [HASH_WORDS];
  logic [7:0]  blk_bytes [64];
  int          blk_fill;
  logic [63:0] msg_bits;

  digest_rec_t digest_due [$];
  int          faults;
  int          cycles;
  int          words_sent;
  int          hold_left;
  bit          no_idle;
  bit          hold_req;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic word_t rol(input word_t x, input int n);
    return (x << n) | (x >> (WORD_W - n));
  endfunction

  function automatic void compress_block();
    word_t w [80];
    word_t a, b, c, d, e, f, k, t_sum;
    for (int t = 0; t < 16; t++) begin
      w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
    end
    for (int t = 16; t < 80; t++) begin
      w[t] = rol(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t_sum = rol(a, 5) + f + e + k + w[t];
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t_sum;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void absorb_byte(input logic [7:0] value);
    blk_bytes[blk_fill] = value;
    blk_fill++;
    if (blk_fill == 64) begin
      compress_block();
      blk_fill = 0;
    end
  endfunction

  function automatic void restart_digest();
    for (int i = 0; i < HASH_WORDS; i++) chain_h[i] = IV[i];
    blk_fill = 0;
    msg_bits = '0;
  endfunction

  function automatic void predict_digest(input logic [7:0] value, input logic bv,
                                         input logic eom, input logic known_empty);
    logic [63:0] len;
    digest_rec_t rec;
    if (bv) begin
      absorb_byte(value);
      msg_bits += 64'd8;
    end
    if (eom) begin
      len = msg_bits;
      absorb_byte(PAD_MARK);
      while (blk_fill != 56) absorb_byte(PAD_ZERO);
      for (int i = 0; i < 8; i++) blk_bytes[56+i] = len[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < HASH_WORDS; i++) begin
        rec.digest_word = known_empty ? EMPTY_DIGEST[i] : chain_h[i];
        rec.word_index  = IDX_W'(i);
        rec.last_word   = (i == HASH_WORDS - 1);
        digest_due.push_back(rec);
      end
      restart_digest();
    end
  endfunction

  task automatic offer_word(input logic [7:0] value, input logic bv, input logic eom,
                            input logic known_empty);
    no_idle = (words_sent >= 150 && words_sent < 260);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(0, 99) < 31) begin
      msg_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    msg_ch.valid          <= 1'b1;
    msg_ch.data_byte      <= value;
    msg_ch.byte_valid     <= bv;
    msg_ch.end_of_message <= eom;
    @(posedge clk_i);
    while (!msg_ch.ready) @(posedge clk_i);
    predict_digest(value, bv, eom, known_empty);
    words_sent++;
  endtask

  task automatic offer_message(input int len);
    bit byte_on_end;
    byte_on_end = (len > 0) && $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 5) begin
        offer_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
      end
      if (byte_on_end && i == len - 1) begin
        offer_word(8'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b0);
      end else begin
        offer_word(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0);
      end
    end
    if (!byte_on_end) offer_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0);
  endtask

  function automatic int pick_length();
    int r;
    int edges [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 20);
    if (r < 85) return edges[$urandom_range(0, 9)];
    return $urandom_range(21, 130);
  endfunction

  // receiver: random back-pressure plus one long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        dig_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        dig_ch.ready <= 1'b0;
      end else begin
        dig_ch.ready <= no_idle || ($urandom_range(0, 99) >= 31);
      end
    end
  end

  always @(posedge clk_i) begin
    digest_rec_t due;
    if (rst_ni && dig_ch.valid && dig_ch.ready) begin
      if (digest_due.size() == 0) begin
        $error("digest word with nothing expected: %h", dig_ch.digest_word);
        faults++;
      end else begin
        due = digest_due.pop_front();
        if (dig_ch.digest_word !== due.digest_word) begin
          $error("digest_word expected %h actual %h", due.digest_word, dig_ch.digest_word);
          faults++;
        end
        if (dig_ch.word_index !== due.word_index) begin
          $error("word_index expected %0d actual %0d", due.word_index, dig_ch.word_index);
          faults++;
        end
        if (dig_ch.last_word !== due.last_word) begin
          $error("last_word expected %0b actual %0b", due.last_word, dig_ch.last_word);
          faults++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int msg_no;
    faults     = 0;
    cycles     = 0;
    words_sent = 0;
    hold_left  = 0;
    no_idle    = 1'b0;
    hold_req   = 1'b0;
    restart_digest();
    for (int i = 0; i < 64; i++) blk_bytes[i] = '0;
    rst_ni                = 1'b0;
    msg_ch.valid          = 1'b0;
    msg_ch.data_byte      = '0;
    msg_ch.byte_valid     = 1'b0;
    msg_ch.end_of_message = 1'b0;
    dig_ch.ready          = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < DIR_COUNT; i++) begin
      offer_word(DIR_ROWS[i].data_byte, DIR_ROWS[i].byte_valid,
                 DIR_ROWS[i].end_of_message, DIR_ROWS[i].known_empty);
    end

    words_sent = 0;
    msg_no     = 0;
    while (words_sent < RAND_WORDS) begin
      if (msg_no == 0) hold_req = 1'b1;
      if (msg_no == 2) begin
        @(negedge clk_i);
        msg_ch.valid <= 1'b0;
        wait (digest_due.size() == 0);
      end
      offer_message(pick_length());
      msg_no++;
    end
    no_idle = 1'b0;
    @(negedge clk_i);
    msg_ch.valid <= 1'b0;

    wait (digest_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (faults == 0 && digest_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
